// File: rtl/fprfc_pkg.sv
// ----------------------------------------------------------------------------
// fprfc_pkg
// Shared constants and types for the FIFO page replacement fault counter.
// ----------------------------------------------------------------------------
package fprfc_pkg;

   localparam int MAX_FRAMES  = 128;
   localparam int PAGE_BITS   = 8;
   localparam int COUNT_BITS  = 16;
   localparam int FC_BITS     = 8;
   localparam int TOTAL_BITS  = 16;

   // Frame index and occupancy widths
   localparam int ADDR_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int OCC_BITS    = $clog2(MAX_FRAMES + 1);
   localparam int CAP_BITS    = (OCC_BITS > FC_BITS) ? OCC_BITS : FC_BITS;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// File: rtl/fprfc_ram.sv
// ----------------------------------------------------------------------------
// fprfc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fprfc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fifo_page_replacement_fault_counter_core.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_fault_counter_core
// FIFO page replacement over a configurable number of frames, with per-run
// fault counting and a flag when a run faults more than the previous one.
// ----------------------------------------------------------------------------
// Usage:
//   Write the frame count on csr_wr_en/csr_wr_data while the block is idle
//   (0 acts as 1, values above the frame store size act as its size).
//   Start a transaction by raising start with req_page, req_end_of_run and
//   req_first_run while busy is low. The block scans the resident frames in
//   the frame memory, one read per cycle, then loads the page on a miss.
//   Every transaction yields one result, shown for exactly one cycle with
//   rsp_valid high; the receiver cannot stall it.
// Scan and handshake:
//   A miss scans every filled frame before the page is loaded; a hit stops
//   the scan at the matching frame. busy drops as rsp_valid rises, so the
//   next start may be taken in that cycle.
//   The scan runs on the single read port of the frame memory, one frame
//   per cycle, up to 128 frames.
// Reset:
//   Synchronous, active high: frames empty, fault counters zero, frame count 1.
//   Frame memory contents are not cleared; only filled frames are ever read.
// ----------------------------------------------------------------------------
module fifo_page_replacement_fault_counter_core
   import fprfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [FC_BITS-1:0]    csr_wr_data,

   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_BITS-1:0]  req_page,
   input  logic                  req_end_of_run,
   input  logic                  req_first_run,

   output logic                  rsp_valid,
   output logic                  rsp_fault,
   output logic                  rsp_run_done,
   output logic [TOTAL_BITS-1:0] rsp_run_fault_total,
   output logic                  rsp_anomaly
);

   state_type state_ff, state_in;

   logic [FC_BITS-1:0]    frame_count_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  last_ff;
   logic                  first_ff;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic [ADDR_BITS-1:0]  oldest_ff, oldest_in;
   logic [COUNT_BITS-1:0] run_faults_ff, run_faults_in;
   logic [COUNT_BITS-1:0] prev_faults_ff, prev_faults_in;
   logic [OCC_BITS-1:0]   idx_ff, idx_in;
   logic                  chk_ff, chk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fault_ff, rsp_fault_in;
   logic                  rsp_run_done_ff, rsp_run_done_in;
   logic [TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_anomaly_ff, rsp_anomaly_in;

   logic                  accept;
   logic                  match;
   logic                  scan_end;
   logic                  done;
   logic [OCC_BITS-1:0]   cap;
   logic [CAP_BITS-1:0]   fc_wide;
   logic [ADDR_BITS-1:0]  slot;
   logic [OCC_BITS-1:0]   slot_inc;
   logic [COUNT_BITS-1:0] total;

   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic                  ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [PAGE_BITS-1:0]  ram_rd_data;

   fprfc_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (page_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Scan status: compare the frame read last cycle, stop on a hit or when
   // every filled frame has been checked.
   assign match    = (state_ff == ST_SCAN) && chk_ff && (ram_rd_data == page_ff);
   assign scan_end = !chk_ff && (idx_ff >= occ_ff);
   assign done     = (state_ff == ST_SCAN) && (match || scan_end);

   // Effective frame count
   assign fc_wide = CAP_BITS'(frame_count_ff);
   always_comb begin
      priority if (fc_wide == '0) begin
         cap = OCC_BITS'(1);
      end else if (fc_wide > CAP_BITS'(MAX_FRAMES)) begin
         cap = OCC_BITS'(MAX_FRAMES);
      end else begin
         cap = OCC_BITS'(fc_wide);
      end
   end

   // Replacement slot when full; wrap when the ring has shrunk
   assign slot     = (OCC_BITS'(oldest_ff) >= occ_ff) ? '0 : oldest_ff;
   assign slot_inc = OCC_BITS'(slot) + OCC_BITS'(1);

   assign total = (run_faults_ff != '1) ? run_faults_ff + COUNT_BITS'(1) : run_faults_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      ram_rd_en       = 1'b0;
      ram_rd_addr     = idx_ff[ADDR_BITS-1:0];
      ram_wr_en       = 1'b0;
      ram_wr_addr     = slot;
      idx_in          = idx_ff;
      chk_in          = 1'b0;
      occ_in          = occ_ff;
      oldest_in       = oldest_ff;
      run_faults_in   = run_faults_ff;
      prev_faults_in  = prev_faults_ff;
      rsp_valid_in    = 1'b0;
      rsp_fault_in    = rsp_fault_ff;
      rsp_run_done_in = rsp_run_done_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_anomaly_in  = rsp_anomaly_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0;
            end
         end
         ST_SCAN: begin
            // Issue the next frame read while the scan goes on
            if (!match && (idx_ff < occ_ff)) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + OCC_BITS'(1);
               chk_in    = 1'b1;
            end
            if (done) begin
               rsp_valid_in    = 1'b1;
               rsp_fault_in    = !match;
               rsp_run_done_in = last_ff;
               rsp_anomaly_in  = 1'b0;
               if (!match) begin
                  ram_wr_en     = 1'b1;
                  run_faults_in = total;
                  if (occ_ff < cap) begin
                     ram_wr_addr = occ_ff[ADDR_BITS-1:0];
                     occ_in      = occ_ff + OCC_BITS'(1);
                  end else begin
                     ram_wr_addr = slot;
                     oldest_in   = (slot_inc >= occ_ff) ? '0 : slot_inc[ADDR_BITS-1:0];
                  end
               end
               rsp_total_in = TOTAL_BITS'(run_faults_in);
               if (last_ff) begin
                  rsp_anomaly_in = !first_ff && (run_faults_in > prev_faults_ff);
                  prev_faults_in = run_faults_in;
                  run_faults_in  = '0;
                  occ_in         = '0;
                  oldest_in      = '0;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= FC_BITS'(1);
         occ_ff         <= '0;
         oldest_ff      <= '0;
         run_faults_ff  <= '0;
         prev_faults_ff <= '0;
         idx_ff         <= '0;
         chk_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
         occ_ff         <= occ_in;
         oldest_ff      <= oldest_in;
         run_faults_ff  <= run_faults_in;
         prev_faults_ff <= prev_faults_in;
         idx_ff         <= idx_in;
         chk_ff         <= chk_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff  <= req_page;
         last_ff  <= req_end_of_run;
         first_ff <= req_first_run;
      end
      rsp_fault_ff    <= rsp_fault_in;
      rsp_run_done_ff <= rsp_run_done_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_anomaly_ff  <= rsp_anomaly_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fault           = rsp_fault_ff;
   assign rsp_run_done        = rsp_run_done_ff;
   assign rsp_run_fault_total = rsp_total_ff;
   assign rsp_anomaly         = rsp_anomaly_ff;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO page replacement fault counter. A
// transaction-level predictor follows every accepted page reference and queues
// the expected result. The checker compares each strobed result with the
// oldest entry in that queue. Stimulus runs in this order: directed runs, frame
// count limits, a resize within a run, and random runs over many frame counts.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fprfc_pkg::*;

   localparam int    STALL_LIMIT   = 3000;
   localparam int    SETTLE_CYCLES = 140;
   localparam int    MAX_REPORTS   = 10;
   localparam int    RANDOM_ITEMS  = 1120;
   localparam longint FAULT_CEILING = (longint'(1) << COUNT_BITS) - 1;

   typedef struct packed {
      logic                  fault;
      logic                  run_done;
      logic [TOTAL_BITS-1:0] total;
      logic                  anomaly;
   } page_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [FC_BITS-1:0]    csr_wr_data = '0;
   logic                  start = 1'b0;
   logic                  busy;
   logic [PAGE_BITS-1:0]  req_page = '0;
   logic                  req_end_of_run = 1'b0;
   logic                  req_first_run = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_fault;
   logic                  rsp_run_done;
   logic [TOTAL_BITS-1:0] rsp_run_fault_total;
   logic                  rsp_anomaly;

   // Predictor state: resident pages, FIFO pointer and the fault totals
   logic [PAGE_BITS-1:0]  resident_pages [MAX_FRAMES];
   int                    resident_count = 0;
   int                    oldest_frame = 0;
   longint                run_fault_count = 0;
   longint                last_run_total = 0;
   logic [FC_BITS-1:0]    frame_setting = FC_BITS'(1);

   page_result_type       expected_results [$];
   int                    mismatch_count = 0;
   int                    stall_cycles = 0;
   bit                    no_gaps = 1'b0;

   fifo_page_replacement_fault_counter_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .start               (start),
      .busy                (busy),
      .req_page            (req_page),
      .req_end_of_run      (req_end_of_run),
      .req_first_run       (req_first_run),
      .rsp_valid           (rsp_valid),
      .rsp_fault           (rsp_fault),
      .rsp_run_done        (rsp_run_done),
      .rsp_run_fault_total (rsp_run_fault_total),
      .rsp_anomaly         (rsp_anomaly)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int usable_frames(logic [FC_BITS-1:0] setting);
      if (setting < 1) return 1;
      if (setting > MAX_FRAMES) return MAX_FRAMES;
      return int'(setting);
   endfunction

   function automatic page_result_type predict_reference(logic [PAGE_BITS-1:0] page,
                                                         logic eor, logic first);
      page_result_type res;
      bit              hit;
      int              slot;
      hit = 1'b0;
      for (int k = 0; k < resident_count; k++)
         if (resident_pages[k] == page) hit = 1'b1;
      if (!hit) begin
         if (resident_count < usable_frames(frame_setting)) begin
            resident_pages[resident_count] = page;
            resident_count++;
         end else begin
            // ring keeps its size even when the frame count shrank below it
            slot = (oldest_frame >= resident_count) ? 0 : oldest_frame;
            resident_pages[slot] = page;
            slot++;
            oldest_frame = (slot >= resident_count) ? 0 : slot;
         end
         if (run_fault_count < FAULT_CEILING) run_fault_count++;
      end
      res.fault    = !hit;
      res.run_done = eor;
      res.total    = run_fault_count[TOTAL_BITS-1:0];
      res.anomaly  = 1'b0;
      if (eor) begin
         res.anomaly     = !first && (run_fault_count > last_run_total);
         last_run_total  = run_fault_count;
         run_fault_count = 0;
         resident_count  = 0;
         oldest_frame    = 0;
      end
      return res;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      page_result_type got;
      page_result_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_fault, rsp_run_done, rsp_run_fault_total, rsp_anomaly};
         if (expected_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result: fault=%b done=%b total=%0d anomaly=%b",
                                   got.fault, got.run_done, got.total, got.anomaly));
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.fault !== want.fault || got.run_done !== want.run_done ||
                got.total !== want.total || got.anomaly !== want.anomaly)
               log_mismatch($sformatf({"result mismatch: expected fault=%b done=%b ",
                                       "total=%0d anomaly=%b, got fault=%b done=%b ",
                                       "total=%0d anomaly=%b"},
                                      want.fault, want.run_done, want.total, want.anomaly,
                                      got.fault, got.run_done, got.total, got.anomaly));
         end
      end
   end

   // Stop a hung run: count cycles with no transaction on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   task automatic send_ref(input logic [PAGE_BITS-1:0] page, input logic eor,
                           input logic first);
      int gap;
      start          <= 1'b1;
      req_page       <= page;
      req_end_of_run <= eor;
      req_first_run  <= first;
      do @(posedge clock); while (busy !== 1'b0);
      expected_results.insert(expected_results.size(), predict_reference(page, eor, first));
      gap = no_gaps ? 0 : gap_length();
      // keep start high for back-to-back transactions
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [FC_BITS-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      frame_setting  = value;
   endtask

   task automatic test_directed_basics();
      // one frame: hit, replace, run end on a hit with first_run set
      send_ref(8'h00, 1'b0, 1'b0);
      send_ref(8'h00, 1'b0, 1'b0);
      send_ref(8'hFF, 1'b0, 1'b0);
      send_ref(8'hFF, 1'b1, 1'b1);
      // three frames: fill, hit, evict the oldest, then fault on it again
      write_frame_count(8'd3);
      send_ref(8'h55, 1'b0, 1'b0);
      send_ref(8'hAA, 1'b0, 1'b0);
      send_ref(8'h0F, 1'b0, 1'b0);
      send_ref(8'h55, 1'b0, 1'b0);
      send_ref(8'hF0, 1'b0, 1'b0);
      send_ref(8'h55, 1'b1, 1'b0);
      // lower, higher and equal totals against the previous run
      send_ref(8'h01, 1'b1, 1'b0);
      send_ref(8'h01, 1'b0, 1'b1);
      send_ref(8'h02, 1'b1, 1'b0);
      send_ref(8'h03, 1'b0, 1'b0);
      send_ref(8'h04, 1'b1, 1'b0);
   endtask

   task automatic test_frame_limits();
      // zero acts as one frame
      write_frame_count(8'd0);
      send_ref(8'h07, 1'b0, 1'b0);
      send_ref(8'h08, 1'b0, 1'b0);
      send_ref(8'h07, 1'b1, 1'b0);
      // above the store size acts as the full store
      write_frame_count(8'd255);
      send_ref(8'h80, 1'b0, 1'b0);
      send_ref(8'h7F, 1'b0, 1'b0);
      send_ref(8'h80, 1'b1, 1'b1);
   endtask

   task automatic test_resize_within_run();
      write_frame_count(8'd4);
      for (int k = 0; k < 4; k++) send_ref(PAGE_BITS'(8'h10 + k), 1'b0, 1'b0);
      // shrink below occupancy, then grow past it, without ending the run
      write_frame_count(8'd2);
      send_ref(8'h20, 1'b0, 1'b0);
      send_ref(8'h11, 1'b0, 1'b0);
      write_frame_count(8'd6);
      send_ref(8'h21, 1'b0, 1'b0);
      send_ref(8'h10, 1'b0, 1'b0);
      send_ref(8'h21, 1'b1, 1'b0);
   endtask

   function automatic logic [FC_BITS-1:0] pick_frame_setting();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3) return FC_BITS'(0);
      if (r < 6) return FC_BITS'(MAX_FRAMES);
      if (r < 8) return FC_BITS'($urandom_range(MAX_FRAMES + 1, 255));
      if (r < 10) return FC_BITS'(1);
      if (r < 15) return FC_BITS'($urandom_range(2, 8));
      return FC_BITS'($urandom_range(9, MAX_FRAMES - 1));
   endfunction

   task automatic test_random_runs();
      int                   sent;
      int                   run_left;
      int                   frames;
      int                   pool;
      int                   base;
      int                   phase_items;
      logic [FC_BITS-1:0]   setting;
      logic [PAGE_BITS-1:0] page;
      sent     = 0;
      run_left = 0;
      while (sent < RANDOM_ITEMS) begin
         // a run may span phases, so the frame count also changes mid-run
         setting = pick_frame_setting();
         write_frame_count(setting);
         frames = usable_frames(setting);
         if ($urandom_range(0, 2) == 0) pool = $urandom_range(1, frames);
         else pool = frames + $urandom_range(1, frames / 2 + 4);
         base        = $urandom_range(0, 255);
         no_gaps     = ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(20, 120);
         repeat (phase_items) begin
            if (run_left == 0)
               run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(frames, 3 * frames + 10)
                                                      : $urandom_range(1, 30);
            if ($urandom_range(0, 9) == 0) page = PAGE_BITS'($urandom_range(0, 255));
            else page = PAGE_BITS'((base + $urandom_range(0, pool - 1)) % 256);
            run_left--;
            send_ref(page, run_left == 0, $urandom_range(0, 7) == 0);
            sent++;
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_frame_limits();
      test_resize_within_run();
      test_random_runs();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
